### design/spsc_pkg.sv
package spsc_pkg;

    localparam int SLOTS_DEF   = 512;
    localparam int ENTRIES_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 32;
    localparam int LEN_W   = 10;
    localparam int TGT_W   = 3;
    localparam int START_W = 9;
    localparam int ERR_W   = 2;

    localparam logic [KIND_W-1:0] KIND_SELECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [TGT_W-1:0] TGT_VERTEX = 3'd0;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_VERTEX = 2'd2;

    localparam logic [1:0] FILL_WIPE    = 2'd0;
    localparam logic [1:0] FILL_RELEASE = 2'd1;
    localparam logic [1:0] FILL_OCCUPY  = 2'd2;

    localparam logic [2:0] RES_ZERO = 3'd0;
    localparam logic [2:0] RES_HIT  = 3'd1;
    localparam logic [2:0] RES_LOAD = 3'd2;
    localparam logic [2:0] RES_ERR1 = 3'd3;
    localparam logic [2:0] RES_ERR2 = 3'd4;

    typedef struct packed {
        logic       load;
        logic       tscan_start;
        logic       fscan_start;
        logic       fill_start;
        logic [1:0] fill_mode;
        logic       plan_normal;
        logic       plan_flush;
        logic       ent_vtx;
        logic       ent_new;
        logic       invalidate;
        logic       hit_take;
        logic       emit;
        logic [2:0] res;
    } cmd_t;

    typedef struct packed {
        logic              tscan_done;
        logic              fscan_done;
        logic              fill_done;
        logic              key_found;
        logic              empty_found;
        logic              vtx_found;
        logic              fit_found;
        logic              too_big;
        logic              len_zero;
        logic              vtx_tgt;
        logic              flush_too_big;
        logic              out_free;
        logic [KIND_W-1:0] kind;
    } sts_t;

endpackage

### design/shader_program_slot_cache_top.sv
// Shader program slot cache. Each input item is a select, remove or clear
// command or an unused kind; every item produces exactly one result item.
// Input channel: in_valid/in_stall with kind, descriptor, length and target.
// Output channel: out_valid/out_stall with start_slot, hit, load_request,
// flushed and error.
// One item is worked on at a time; in_stall is high from acceptance until the
// result has been written to the output register.
// A select or remove scans the program table. A select that misses with a
// nonzero length then scans the free slot map, and marks the new program's
// slots, one slot per cycle. A flush or a clear sweeps the whole slot map.
// After reset the slot map is cleared in one pass during which no item is
// accepted.
// A stalled result holds in the output register. The next item is accepted
// meanwhile, and its result waits until the register is free.
module shader_program_slot_cache_top
    import spsc_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   descriptor,
    input  logic [LEN_W-1:0]   length,
    input  logic [TGT_W-1:0]   target,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [START_W-1:0] start_slot,
    output logic               hit,
    output logic               load_request,
    output logic               flushed,
    output logic [ERR_W-1:0]   error
);

    cmd_t cmd;
    sts_t sts;

    spsc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    spsc_dp #(.SLOTS(SLOTS), .ENTRIES(ENTRIES)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .descriptor   (descriptor),
        .length       (length),
        .target       (target),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .start_slot   (start_slot),
        .hit          (hit),
        .load_request (load_request),
        .flushed      (flushed),
        .error        (error)
    );

endmodule

### design/spsc_ram.sv
module spsc_ram
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/spsc_ctrl.sv
module spsc_ctrl
    import spsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_BOOT  = 4'd0;
    localparam logic [3:0] ST_BWAIT = 4'd1;
    localparam logic [3:0] ST_IDLE  = 4'd2;
    localparam logic [3:0] ST_DISP  = 4'd3;
    localparam logic [3:0] ST_CLRW  = 4'd4;
    localparam logic [3:0] ST_TSCAN = 4'd5;
    localparam logic [3:0] ST_RELW  = 4'd6;
    localparam logic [3:0] ST_FSCAN = 4'd7;
    localparam logic [3:0] ST_FLUSH = 4'd8;
    localparam logic [3:0] ST_FWIPE = 4'd9;
    localparam logic [3:0] ST_ENTN  = 4'd10;
    localparam logic [3:0] ST_OCCW  = 4'd11;
    localparam logic [3:0] ST_EMIT  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] res_reg;
    logic [2:0] res_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        unique case (state_reg)
            ST_BOOT:
            begin
                cmd.fill_start = 1'b1;
                cmd.fill_mode  = FILL_WIPE;
                state_next     = ST_BWAIT;
            end
            ST_BWAIT:
            begin
                if (sts.fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (sts.kind == KIND_CLEAR)
                begin
                    cmd.fill_start = 1'b1;
                    cmd.fill_mode  = FILL_WIPE;
                    state_next     = ST_CLRW;
                end
                else if (sts.kind == KIND_SELECT || sts.kind == KIND_REMOVE)
                begin
                    cmd.tscan_start = 1'b1;
                    state_next      = ST_TSCAN;
                end
                else
                begin
                    res_next   = RES_ZERO;
                    state_next = ST_EMIT;
                end
            end
            ST_CLRW:
            begin
                if (sts.fill_done)
                begin
                    res_next   = RES_ZERO;
                    state_next = ST_EMIT;
                end
            end
            ST_TSCAN:
            begin
                if (sts.tscan_done)
                begin
                    if (sts.kind == KIND_REMOVE)
                    begin
                        if (sts.key_found)
                        begin
                            cmd.fill_start = 1'b1;
                            cmd.fill_mode  = FILL_RELEASE;
                            state_next     = ST_RELW;
                        end
                        else
                        begin
                            res_next   = RES_ZERO;
                            state_next = ST_EMIT;
                        end
                    end
                    else if (sts.key_found)
                    begin
                        cmd.hit_take = 1'b1;
                        res_next     = RES_HIT;
                        state_next   = ST_EMIT;
                    end
                    else if (sts.too_big)
                    begin
                        res_next   = RES_ERR1;
                        state_next = ST_EMIT;
                    end
                    else if (sts.len_zero)
                    begin
                        if (sts.empty_found)
                        begin
                            cmd.plan_normal = 1'b1;
                            state_next      = ST_ENTN;
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        cmd.fscan_start = 1'b1;
                        state_next      = ST_FSCAN;
                    end
                end
            end
            ST_RELW:
            begin
                if (sts.fill_done)
                begin
                    cmd.invalidate = 1'b1;
                    res_next       = RES_ZERO;
                    state_next     = ST_EMIT;
                end
            end
            ST_FSCAN:
            begin
                if (sts.fscan_done)
                begin
                    if (sts.fit_found && sts.empty_found)
                    begin
                        cmd.plan_normal = 1'b1;
                        state_next      = ST_ENTN;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!sts.vtx_tgt && !sts.vtx_found)
                begin
                    res_next   = RES_ERR2;
                    state_next = ST_EMIT;
                end
                else if (!sts.vtx_tgt && sts.flush_too_big)
                begin
                    res_next   = RES_ERR1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.plan_flush = 1'b1;
                    cmd.fill_start = 1'b1;
                    cmd.fill_mode  = FILL_WIPE;
                    state_next     = ST_FWIPE;
                end
            end
            ST_FWIPE:
            begin
                if (sts.fill_done)
                begin
                    cmd.ent_vtx = !sts.vtx_tgt;
                    state_next  = ST_ENTN;
                end
            end
            ST_ENTN:
            begin
                cmd.ent_new    = 1'b1;
                cmd.fill_start = 1'b1;
                cmd.fill_mode  = FILL_OCCUPY;
                state_next     = ST_OCCW;
            end
            ST_OCCW:
            begin
                if (sts.fill_done)
                begin
                    res_next   = RES_LOAD;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_BOOT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
            res_reg   <= RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

### design/spsc_dp.sv
module spsc_dp
    import spsc_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   descriptor,
    input  logic [LEN_W-1:0]   length,
    input  logic [TGT_W-1:0]   target,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [START_W-1:0] start_slot,
    output logic               hit,
    output logic               load_request,
    output logic               flushed,
    output logic [ERR_W-1:0]   error
);

    localparam int SW  = $clog2(SLOTS);
    localparam int EW  = $clog2(ENTRIES);
    localparam int PW  = SW + 1;
    localparam int CW  = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int RW  = KEY_W + PW + LEN_W + TGT_W;

    logic [KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic [KEY_W-1:0]  lvk_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic              tact_reg;
    logic [EW:0]       tcnt_reg;
    logic              tchk_reg;
    logic [EW-1:0]     tidx_reg;
    logic              kf_reg;
    logic              ef_reg;
    logic              vf_reg;
    logic [EW-1:0]     kidx_reg;
    logic [EW-1:0]     eidx_reg;
    logic [PW-1:0]     kstart_reg;
    logic [LEN_W-1:0]  klen_reg;
    logic [LEN_W-1:0]  vlen_reg;
    logic [TGT_W-1:0]  vtgt_reg;

    logic              fact_reg;
    logic [CW-1:0]     fcnt_reg;
    logic              fchk_reg;
    logic [SW-1:0]     fidx_reg;
    logic [CW-1:0]     run_reg;
    logic              found_reg;
    logic [PW-1:0]     fpos_reg;

    logic              fill_act_reg;
    logic              fill_val_reg;
    logic [CW-1:0]     fill_hi_reg;

    logic [PW-1:0]     pos_reg;
    logic [EW-1:0]     ent_reg;
    logic              flushed_reg;

    logic               out_vld_reg;
    logic [START_W-1:0] out_start_reg;
    logic               out_hit_reg;
    logic               out_load_reg;
    logic               out_flushed_reg;
    logic [ERR_W-1:0]   out_err_reg;

    logic              slot_we;
    logic              slot_rdata;
    logic              ent_we;
    logic [EW-1:0]     ent_waddr;
    logic [RW-1:0]     ent_wdata;
    logic [RW-1:0]     ent_rdata;
    logic [KEY_W-1:0]  r_key;
    logic [PW-1:0]     r_start;
    logic [LEN_W-1:0]  r_len;
    logic [TGT_W-1:0]  r_tgt;
    logic              tdone;
    logic              fdone;
    logic              fill_done;
    logic [CW-1:0]     run_inc;
    logic [CW-1:0]     rel_end;
    logic [CW-1:0]     rel_hi;
    logic              out_free;

    assign r_key   = ent_rdata[RW-1 -: KEY_W];
    assign r_start = ent_rdata[TGT_W+LEN_W +: PW];
    assign r_len   = ent_rdata[TGT_W +: LEN_W];
    assign r_tgt   = ent_rdata[TGT_W-1:0];

    assign tdone     = tact_reg && (tcnt_reg == (EW+1)'(ENTRIES)) && !tchk_reg;
    assign fdone     = fact_reg && (found_reg || ((fcnt_reg == CW'(SLOTS)) && !fchk_reg));
    assign fill_done = fill_act_reg && (fcnt_reg >= fill_hi_reg);
    assign run_inc   = run_reg + CW'(1);
    assign rel_end   = CW'(kstart_reg) + CW'(klen_reg);
    assign rel_hi    = (rel_end > CW'(SLOTS)) ? CW'(SLOTS) : rel_end;
    assign out_free  = !out_vld_reg || !out_stall;

    assign slot_we   = fill_act_reg && (fcnt_reg < fill_hi_reg);
    assign ent_we    = cmd.ent_new || cmd.ent_vtx;
    assign ent_waddr = cmd.ent_vtx ? '0 : ent_reg;
    assign ent_wdata = cmd.ent_vtx ? {lvk_reg, PW'(0), vlen_reg, vtgt_reg}
                                   : {key_reg, pos_reg, len_reg, tgt_reg};

    spsc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_slot_ram
    (
        .clk   (clk),
        .we    (slot_we),
        .waddr (fcnt_reg[SW-1:0]),
        .wdata (fill_val_reg),
        .raddr (fcnt_reg[SW-1:0]),
        .rdata (slot_rdata)
    );

    spsc_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_entry_ram
    (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (tcnt_reg[EW-1:0]),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        sts.tscan_done    = tdone;
        sts.fscan_done    = fdone;
        sts.fill_done     = fill_done;
        sts.key_found     = kf_reg;
        sts.empty_found   = ef_reg;
        sts.vtx_found     = vf_reg;
        sts.fit_found     = found_reg;
        sts.too_big       = CW'(len_reg) > CW'(SLOTS);
        sts.len_zero      = (len_reg == '0);
        sts.vtx_tgt       = (tgt_reg == TGT_VERTEX);
        sts.flush_too_big = (CW'(vlen_reg) + CW'(len_reg)) > CW'(SLOTS);
        sts.out_free      = out_free;
        sts.kind          = kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_SELECT;
            key_reg         <= '0;
            len_reg         <= '0;
            tgt_reg         <= '0;
            lvk_reg         <= '0;
            valid_reg       <= '0;
            tact_reg        <= 1'b0;
            tcnt_reg        <= '0;
            tchk_reg        <= 1'b0;
            tidx_reg        <= '0;
            kf_reg          <= 1'b0;
            ef_reg          <= 1'b0;
            vf_reg          <= 1'b0;
            kidx_reg        <= '0;
            eidx_reg        <= '0;
            kstart_reg      <= '0;
            klen_reg        <= '0;
            vlen_reg        <= '0;
            vtgt_reg        <= '0;
            fact_reg        <= 1'b0;
            fcnt_reg        <= '0;
            fchk_reg        <= 1'b0;
            fidx_reg        <= '0;
            run_reg         <= '0;
            found_reg       <= 1'b0;
            fpos_reg        <= '0;
            fill_act_reg    <= 1'b0;
            fill_val_reg    <= 1'b0;
            fill_hi_reg     <= '0;
            pos_reg         <= '0;
            ent_reg         <= '0;
            flushed_reg     <= 1'b0;
            out_vld_reg     <= 1'b0;
            out_start_reg   <= '0;
            out_hit_reg     <= 1'b0;
            out_load_reg    <= 1'b0;
            out_flushed_reg <= 1'b0;
            out_err_reg     <= ERR_NONE;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg    <= kind;
                key_reg     <= descriptor;
                len_reg     <= length;
                tgt_reg     <= target;
                flushed_reg <= 1'b0;
            end

            if (cmd.tscan_start)
            begin
                tact_reg <= 1'b1;
                tcnt_reg <= '0;
                tchk_reg <= 1'b0;
                kf_reg   <= 1'b0;
                ef_reg   <= 1'b0;
                vf_reg   <= 1'b0;
            end
            else if (tact_reg)
            begin
                if (tdone)
                begin
                    tact_reg <= 1'b0;
                end
                tchk_reg <= (tcnt_reg < (EW+1)'(ENTRIES));
                if (tcnt_reg < (EW+1)'(ENTRIES))
                begin
                    tcnt_reg <= tcnt_reg + (EW+1)'(1);
                    tidx_reg <= tcnt_reg[EW-1:0];
                end
                if (tchk_reg)
                begin
                    if (valid_reg[tidx_reg] && r_key == key_reg && !kf_reg)
                    begin
                        kf_reg     <= 1'b1;
                        kidx_reg   <= tidx_reg;
                        kstart_reg <= r_start;
                        klen_reg   <= r_len;
                    end
                    if (!valid_reg[tidx_reg] && !ef_reg)
                    begin
                        ef_reg   <= 1'b1;
                        eidx_reg <= tidx_reg;
                    end
                    if (valid_reg[tidx_reg] && r_key == lvk_reg && !vf_reg)
                    begin
                        vf_reg   <= 1'b1;
                        vlen_reg <= r_len;
                        vtgt_reg <= r_tgt;
                    end
                end
            end

            if (cmd.fscan_start)
            begin
                fact_reg  <= 1'b1;
                fcnt_reg  <= '0;
                fchk_reg  <= 1'b0;
                run_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (fact_reg)
            begin
                if (fdone)
                begin
                    fact_reg <= 1'b0;
                end
                fchk_reg <= !found_reg && (fcnt_reg < CW'(SLOTS));
                if (!found_reg && fcnt_reg < CW'(SLOTS))
                begin
                    fcnt_reg <= fcnt_reg + CW'(1);
                    fidx_reg <= fcnt_reg[SW-1:0];
                end
                if (fchk_reg && !found_reg)
                begin
                    if (slot_rdata)
                    begin
                        run_reg <= run_inc;
                        if (run_inc == CW'(len_reg))
                        begin
                            found_reg <= 1'b1;
                            fpos_reg  <= PW'(CW'(fidx_reg) + CW'(1) - CW'(len_reg));
                        end
                    end
                    else
                    begin
                        run_reg <= '0;
                    end
                end
            end

            if (cmd.fill_start)
            begin
                fill_act_reg <= 1'b1;
                unique case (cmd.fill_mode)
                    FILL_WIPE:
                    begin
                        fcnt_reg     <= '0;
                        fill_hi_reg  <= CW'(SLOTS);
                        fill_val_reg <= 1'b1;
                        valid_reg    <= '0;
                    end
                    FILL_RELEASE:
                    begin
                        fcnt_reg     <= CW'(kstart_reg);
                        fill_hi_reg  <= rel_hi;
                        fill_val_reg <= 1'b1;
                    end
                    default:
                    begin
                        fcnt_reg     <= flushed_reg ? '0 : CW'(pos_reg);
                        fill_hi_reg  <= CW'(pos_reg) + CW'(len_reg);
                        fill_val_reg <= 1'b0;
                    end
                endcase
            end
            else if (fill_act_reg)
            begin
                if (fill_done)
                begin
                    fill_act_reg <= 1'b0;
                end
                else
                begin
                    fcnt_reg <= fcnt_reg + CW'(1);
                end
            end

            if (cmd.plan_normal)
            begin
                pos_reg <= (len_reg == '0) ? '0 : fpos_reg;
                ent_reg <= eidx_reg;
            end
            if (cmd.plan_flush)
            begin
                flushed_reg <= 1'b1;
                if (tgt_reg == TGT_VERTEX)
                begin
                    pos_reg <= '0;
                    ent_reg <= '0;
                end
                else
                begin
                    pos_reg <= PW'(vlen_reg);
                    ent_reg <= EW'(1);
                end
            end

            if (cmd.ent_vtx)
            begin
                valid_reg[0] <= 1'b1;
            end
            if (cmd.ent_new)
            begin
                valid_reg[ent_reg] <= 1'b1;
                if (tgt_reg == TGT_VERTEX)
                begin
                    lvk_reg <= key_reg;
                end
            end
            if (cmd.invalidate)
            begin
                valid_reg[kidx_reg] <= 1'b0;
            end
            if (cmd.hit_take && tgt_reg == TGT_VERTEX)
            begin
                lvk_reg <= key_reg;
            end

            if (cmd.emit)
            begin
                out_vld_reg     <= 1'b1;
                out_hit_reg     <= (cmd.res == RES_HIT);
                out_load_reg    <= (cmd.res == RES_LOAD);
                out_flushed_reg <= (cmd.res == RES_LOAD) && flushed_reg;
                if (cmd.res == RES_HIT)
                begin
                    out_start_reg <= START_W'(kstart_reg);
                end
                else if (cmd.res == RES_LOAD)
                begin
                    out_start_reg <= START_W'(pos_reg);
                end
                else
                begin
                    out_start_reg <= '0;
                end
                if (cmd.res == RES_ERR1)
                begin
                    out_err_reg <= ERR_TOO_LARGE;
                end
                else if (cmd.res == RES_ERR2)
                begin
                    out_err_reg <= ERR_NO_VERTEX;
                end
                else
                begin
                    out_err_reg <= ERR_NONE;
                end
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign start_slot   = out_start_reg;
    assign hit          = out_hit_reg;
    assign load_request = out_load_reg;
    assign flushed      = out_flushed_reg;
    assign error        = out_err_reg;

endmodule

### design/spsc_chk.sv
module spsc_chk
    import spsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [KIND_W-1:0]  kind,
    input logic [KEY_W-1:0]   descriptor,
    input logic [LEN_W-1:0]   length,
    input logic [TGT_W-1:0]   target,
    input logic               out_valid,
    input logic               out_stall,
    input logic [START_W-1:0] start_slot,
    input logic               hit,
    input logic               load_request,
    input logic               flushed,
    input logic [ERR_W-1:0]   error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Stalled result was dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Item accepted while another is in work.");

    a_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && load_request))
        else $error("Result is both a hit and a load.");

    a_flush_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flushed |-> load_request)
        else $error("Flush reported without a load.");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error != ERR_NONE |-> !hit && !load_request && start_slot == '0)
        else $error("Error result carries other fields.");

endmodule

bind shader_program_slot_cache_top spsc_chk u_spsc_chk (.*);

### bench/shader_program_slot_cache_top_tb.sv
`timescale 1ns / 100ps

module shader_program_slot_cache_top_tb;
    import spsc_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NENT = ENTRIES_DEF;
    localparam int WATCHDOG = 40000;
    localparam int NDIR = 22;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [TGT_W-1:0]  tgt;
    } cmd_item_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic               hit;
        logic               load;
        logic               flushed;
        logic [ERR_W-1:0]   err;
    } res_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [KIND_W-1:0] kind = '0;
    logic [KEY_W-1:0] descriptor = '0;
    logic [LEN_W-1:0] length = '0;
    logic [TGT_W-1:0] target = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [START_W-1:0] start_slot;
    logic hit;
    logic load_request;
    logic flushed;
    logic [ERR_W-1:0] error;

    shader_program_slot_cache_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .descriptor(descriptor), .length(length), .target(target),
        .out_valid(out_valid), .out_stall(out_stall),
        .start_slot(start_slot), .hit(hit), .load_request(load_request),
        .flushed(flushed), .error(error)
    );

    always #6 clk = ~clk;

    bit        mem_free [NSLOT];
    bit        prog_valid [NENT];
    bit [31:0] prog_key [NENT];
    int        prog_start [NENT];
    int        prog_len [NENT];
    bit [2:0]  prog_tgt [NENT];
    bit [31:0] vertex_key;

    res_item_t pending_results[$];
    int errors = 0;
    int checked = 0;
    int n_hits = 0;
    int n_flush = 0;
    int n_err = 0;
    int idle_in_pct = 0;
    int stall_out_pct = 0;
    int quiet_cycles = 0;
    bit sending_done = 1'b0;

    function automatic void wipe_cache();
        for (int i = 0; i < NSLOT; i++) mem_free[i] = 1'b1;
        for (int e = 0; e < NENT; e++) prog_valid[e] = 1'b0;
    endfunction

    function automatic int lookup_key(bit [31:0] k);
        for (int e = 0; e < NENT; e++)
            if (prog_valid[e] && prog_key[e] == k) return e;
        return -1;
    endfunction

    function automatic int free_entry();
        for (int e = 0; e < NENT; e++)
            if (!prog_valid[e]) return e;
        return -1;
    endfunction

    function automatic int fit_run(int n);
        int run;
        run = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (mem_free[i]) begin
                run++;
                if (run == n) return i + 1 - n;
            end
            else run = 0;
        end
        return -1;
    endfunction

    function automatic void place_prog(int e, bit [31:0] k, int s, int n, bit [2:0] t);
        for (int i = 0; i < n && s + i < NSLOT; i++) mem_free[s + i] = 1'b0;
        prog_valid[e] = 1'b1;
        prog_key[e] = k;
        prog_start[e] = s;
        prog_len[e] = n;
        prog_tgt[e] = t;
    endfunction

    function automatic res_item_t cache_step(cmd_item_t c);
        res_item_t r;
        int e;
        int pos;
        int slot;
        int v;
        int vlen;
        bit [2:0] vtgt;
        r = '0;
        if (c.kind == KIND_REMOVE) begin
            e = lookup_key(c.key);
            if (e >= 0) begin
                for (int i = 0; i < prog_len[e] && prog_start[e] + i < NSLOT; i++)
                    mem_free[prog_start[e] + i] = 1'b1;
                prog_valid[e] = 1'b0;
            end
        end
        else if (c.kind == KIND_CLEAR) begin
            wipe_cache();
        end
        else if (c.kind == KIND_SELECT) begin
            e = lookup_key(c.key);
            if (e >= 0) begin
                r.start = START_W'(prog_start[e]);
                r.hit = 1'b1;
                if (c.tgt == TGT_VERTEX) vertex_key = c.key;
            end
            else if (c.len > NSLOT) begin
                r.err = ERR_TOO_LARGE;
            end
            else begin
                pos = (c.len == 0) ? 0 : fit_run(c.len);
                slot = free_entry();
                if (pos < 0 || slot < 0) begin
                    if (c.tgt == TGT_VERTEX) begin
                        wipe_cache();
                        slot = 0;
                        pos = 0;
                        r.flushed = 1'b1;
                    end
                    else begin
                        v = lookup_key(vertex_key);
                        if (v < 0) r.err = ERR_NO_VERTEX;
                        else if (prog_len[v] + c.len > NSLOT) r.err = ERR_TOO_LARGE;
                        else begin
                            vlen = prog_len[v];
                            vtgt = prog_tgt[v];
                            wipe_cache();
                            place_prog(0, vertex_key, 0, vlen, vtgt);
                            slot = 1;
                            pos = vlen;
                            r.flushed = 1'b1;
                        end
                    end
                end
                if (r.err == ERR_NONE) begin
                    place_prog(slot, c.key, pos, c.len, c.tgt);
                    r.start = START_W'(pos);
                    r.load = 1'b1;
                    if (c.tgt == TGT_VERTEX) vertex_key = c.key;
                end
            end
        end
        return r;
    endfunction

    task automatic send_cmd(cmd_item_t c, bit has_known, res_item_t known);
        res_item_t r;
        while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= c.kind;
        descriptor <= c.key;
        length <= c.len;
        target <= c.tgt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = cache_step(c);
        if (has_known && r !== known) begin
            errors++;
            if (errors <= 10)
                $display("table row: expected %h, predicted %h", known, r);
        end
        pending_results.push_back(r);
        @(negedge clk);
    endtask

    always @(posedge clk) begin
        res_item_t got;
        res_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{start_slot, hit, load_request, flushed, error};
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
            end
            else begin
                want = pending_results.pop_front();
                checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected start=%0d hit=%b load=%b fl=%b err=%0d, got start=%0d hit=%b load=%b fl=%b err=%0d",
                                 checked, want.start, want.hit, want.load, want.flushed,
                                 want.err, got.start, got.hit, got.load, got.flushed, got.err);
                end
                if (want.hit) n_hits++;
                if (want.flushed) n_flush++;
                if (want.err != ERR_NONE) n_err++;
            end
        end
    end

    always @(negedge clk) begin
        out_stall <= (stall_out_pct > 0 && $urandom_range(99) < stall_out_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("shader_program_slot_cache_top: mismatch");
            $finish;
        end
    end

    cmd_item_t dir_cmd [NDIR];
    res_item_t dir_res [NDIR];
    bit        dir_known [NDIR];

    function automatic cmd_item_t mk(bit [1:0] k, bit [31:0] d, int n, bit [2:0] t);
        cmd_item_t c;
        c.kind = k;
        c.key = d;
        c.len = LEN_W'(n);
        c.tgt = t;
        return c;
    endfunction

    function automatic res_item_t rk(int s, bit h, bit l, bit f, bit [1:0] e);
        res_item_t r;
        r.start = START_W'(s);
        r.hit = h;
        r.load = l;
        r.flushed = f;
        r.err = e;
        return r;
    endfunction

    task automatic set_row(int i, cmd_item_t c, res_item_t r, bit k);
        dir_cmd[i] = c;
        dir_res[i] = r;
        dir_known[i] = k;
    endtask

    task automatic fill_table();
        set_row(0, mk(KIND_SELECT, 32'h0, 1, 3'd1), rk(0, 0, 1, 0, ERR_NONE), 0);
        set_row(1, mk(KIND_SELECT, 32'h1, 513, 3'd0), rk(0, 0, 0, 0, ERR_TOO_LARGE), 1);
        set_row(2, mk(KIND_SELECT, 32'h1, 1023, 3'd7), rk(0, 0, 0, 0, ERR_TOO_LARGE), 1);
        set_row(3, mk(KIND_SELECT, 32'hFFFFFFFF, 100, 3'd0), rk(1, 0, 1, 0, ERR_NONE), 1);
        set_row(4, mk(KIND_SELECT, 32'hFFFFFFFF, 5, 3'd2), rk(1, 1, 0, 0, ERR_NONE), 1);
        set_row(5, mk(KIND_SELECT, 32'hA5A5A5A5, 0, 3'd1), rk(0, 0, 1, 0, ERR_NONE), 1);
        set_row(6, mk(KIND_SELECT, 32'h2, 412, 3'd1), rk(100, 0, 1, 1, ERR_NONE), 1);
        set_row(7, mk(KIND_SELECT, 32'h3, 1, 3'd4), rk(100, 0, 1, 1, ERR_NONE), 0);
        set_row(8, mk(KIND_SELECT, 32'h4, 500, 3'd5), rk(0, 0, 0, 0, ERR_TOO_LARGE), 0);
        set_row(9, mk(KIND_REMOVE, 32'h3, 0, 3'd0), rk(0, 0, 0, 0, ERR_NONE), 1);
        set_row(10, mk(KIND_REMOVE, 32'h12345678, 0, 3'd0), rk(0, 0, 0, 0, ERR_NONE), 1);
        set_row(11, mk(KIND_UNUSED, 32'h5, 7, 3'd6), rk(0, 0, 0, 0, ERR_NONE), 1);
        set_row(12, mk(KIND_SELECT, 32'h6, 512, 3'd0), rk(0, 0, 1, 1, ERR_NONE), 0);
        set_row(13, mk(KIND_SELECT, 32'h7, 1, 3'd3), rk(0, 0, 0, 0, ERR_TOO_LARGE), 0);
        set_row(14, mk(KIND_CLEAR, 32'h0, 0, 3'd0), rk(0, 0, 0, 0, ERR_NONE), 1);
        set_row(15, mk(KIND_SELECT, 32'h6, 3, 3'd0), rk(0, 0, 1, 0, ERR_NONE), 1);
        set_row(16, mk(KIND_SELECT, 32'h8, 509, 3'd6), rk(3, 0, 1, 0, ERR_NONE), 1);
        set_row(17, mk(KIND_SELECT, 32'h9, 509, 3'd7), rk(3, 0, 1, 1, ERR_NONE), 0);
        set_row(18, mk(KIND_SELECT, 32'h9, 0, 3'd0), rk(3, 1, 0, 0, ERR_NONE), 0);
        set_row(19, mk(KIND_REMOVE, 32'h9, 0, 3'd0), rk(0, 0, 0, 0, ERR_NONE), 1);
        set_row(20, mk(KIND_SELECT, 32'hA, 2, 3'd1), rk(3, 0, 1, 0, ERR_NONE), 0);
        set_row(21, mk(KIND_CLEAR, 32'hFFFFFFFF, 1023, 3'd7), rk(0, 0, 0, 0, ERR_NONE), 1);
    endtask

    function automatic cmd_item_t random_cmd(int phase);
        cmd_item_t c;
        int r;
        r = $urandom_range(99);
        c.key = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(40);
        c.tgt = ($urandom_range(2) == 0) ? TGT_VERTEX : TGT_W'($urandom_range(7));
        c.len = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(1023))
                : (($urandom_range(7) == 0) ? LEN_W'($urandom_range(512))
                                            : LEN_W'($urandom_range(40)));
        if (r < 70) c.kind = KIND_SELECT;
        else if (r < 92) c.kind = KIND_REMOVE;
        else if (r < 97) c.kind = KIND_CLEAR;
        else c.kind = KIND_UNUSED;
        if (phase == 0 && c.len > 0 && $urandom_range(3) == 0)
            c.len = LEN_W'($urandom_range(1, 8));
        return c;
    endfunction

    initial begin
        int pct_in [5] = '{0, 60, 0, 19, 0};
        int pct_out [5] = '{0, 0, 60, 19, 0};
        wipe_cache();
        vertex_key = '0;
        fill_table();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < NDIR; i++) send_cmd(dir_cmd[i], dir_known[i], dir_res[i]);
        for (int p = 0; p < 5; p++) begin
            idle_in_pct = pct_in[p];
            stall_out_pct = pct_out[p];
            for (int j = 0; j < 180; j++) send_cmd(random_cmd(p), 1'b0, '0);
        end
        in_valid <= 1'b0;
        stall_out_pct = 0;
        idle_in_pct = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        $display("Covered %0d results: %0d hits, %0d flushes, %0d errors,", checked, n_hits,
                 n_flush, n_err);
        $display("over directed corner rows and five idle/stall mixes.");
        if (errors == 0 && pending_results.size() == 0)
            $display("shader_program_slot_cache_top: match");
        else
            $display("shader_program_slot_cache_top: mismatch");
        $finish;
    end

endmodule

### filelist.f
design/spsc_pkg.sv
design/spsc_ram.sv
design/spsc_ctrl.sv
design/spsc_dp.sv
design/shader_program_slot_cache_top.sv
design/spsc_chk.sv
bench/shader_program_slot_cache_top_tb.sv
